@@ design/kji_pkg.sv @@
// Package for the keyframe joint interpolator.
// Holds the shared arithmetic unit's request type, the input mode codes and constants.
// No dependencies.
package kji_pkg;

    localparam int ALU_W = 64;
    localparam int PROG_BITS = 24;
    localparam logic [15:0] SCALE_ONE = 16'd256;
    localparam logic [19:0] SPEED_MS_MUL = 20'd1000;
    localparam logic [19:0] SPEED_ZERO_MUL = 20'd1000000;

    localparam logic [1:0] MODE_SET_START = 2'd0;
    localparam logic [1:0] MODE_SET_GOAL = 2'd1;
    localparam logic [1:0] MODE_BEGIN_FRAME = 2'd2;
    localparam logic [1:0] MODE_STEP = 2'd3;

    localparam logic CFG_CYCLE_MS = 1'b0;
    localparam logic CFG_ACTIVE_JOINTS = 1'b1;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic       start;
        alu_op_t    op;
        logic [6:0] nbits;
    } alu_req_t;

endpackage

@@ design/kji_alu.sv @@
// Shared bit-serial arithmetic unit: shift-add multiply and restoring divide.
// Depends on kji_pkg.
module kji_alu import kji_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  alu_req_t         req,
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    output logic             done,
    output logic [ALU_W-1:0] result
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    alu_op_t          op_reg, op_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic [ALU_W:0]   acc_reg, acc_next;
    logic [ALU_W-1:0] x_reg, x_next;
    logic [ALU_W-1:0] y_reg, y_next;
    logic [ALU_W:0]   rem_sh;
    logic             ge;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next = op_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        x_next = x_reg;
        y_next = y_reg;
        rem_sh = {acc_reg[ALU_W-1:0], x_reg[ALU_W-1]};
        ge = rem_sh >= {1'b0, y_reg};
        if (!busy_reg) begin
            if (req.start) begin
                busy_next = 1'b1;
                op_next = req.op;
                cnt_next = (req.op == ALU_DIV) ? 7'(ALU_W - 1) : req.nbits - 7'd1;
                acc_next = '0;
                x_next = a;
                y_next = b;
            end
        end else begin
            if (op_reg == ALU_DIV) begin
                acc_next = ge ? rem_sh - {1'b0, y_reg} : rem_sh;
                x_next = {x_reg[ALU_W-2:0], ge};
            end else begin
                if (y_reg[0]) begin
                    acc_next = {1'b0, acc_reg[ALU_W-1:0] + x_reg};
                end
                x_next = {x_reg[ALU_W-2:0], 1'b0};
                y_next = {1'b0, y_reg[ALU_W-1:1]};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        op_reg <= op_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign done = done_reg;
    assign result = (op_reg == ALU_DIV) ? x_reg : acc_reg[ALU_W-1:0];

endmodule

@@ design/keyframe_joint_interpolator_core.sv @@
// Top level of the keyframe joint interpolator: stream ports, joint stores and sequencer.
// Depends on kji_pkg and kji_alu.
//
// This block turns keyframes into per-joint servo set-points by linear interpolation. Each
// input word carries a mode in tuser. Set-start and set-goal words only update the joint
// stores. A begin-frame word works out the step count and each joint's move time with one
// division per joint. A step word emits one point, one output word per active joint;
// joints that hold still, and all joints when no frame is begun, skip the arithmetic.
// The arithmetic goes to one shared bit-serial unit that multiplies or divides one bit
// per cycle, driven by the sequencer below. The input side is not ready while a word is
// being worked on; each output word is held in registers until the sink takes it. After
// the final step of a frame the goals become the new start positions. Positions are Q16.16
// radians, speeds Q16.16 radians per second saturated at the maximum.
module keyframe_joint_interpolator_core import kji_pkg::*; #(
    parameter int MAX_JOINTS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // joint[4:0], position[36:5], scale[52:37], has_goal[53], move_ms[69:54],
    // wait_ms[85:70], zero fill above
    input  logic [87:0]  s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // joint_index[4:0], set_position[36:5], set_speed[68:37], time_ms[100:69], zero fill above
    output logic [103:0] m_axis_tdata,
    // last of a point
    output logic         m_axis_tlast,
    // frame_done[0]
    output logic         m_axis_tuser,
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [9:0]   cfg_wdata
);

    localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int JCW = ($clog2(MAX_JOINTS + 1) > 6) ? $clog2(MAX_JOINTS + 1) : 6;
    localparam logic [JCW-1:0] JMAX = JCW'(MAX_JOINTS);
    localparam logic [JCW-1:0] JLAST = JCW'(MAX_JOINTS - 1);
    localparam logic [24:0] PROG_ONE = 25'(1) << PROG_BITS;
    localparam logic [56:0] PROG_ROUND = 57'((64'd1 << PROG_BITS) - 64'd1);

    // One-hot sequencer states.
    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_STEPS = 12'b0000_0000_0010,
        ST_MOVE  = 12'b0000_0000_0100,
        ST_NUM   = 12'b0000_0000_1000,
        ST_TIME  = 12'b0000_0001_0000,
        ST_LOAD  = 12'b0000_0010_0000,
        ST_DEN   = 12'b0000_0100_0000,
        ST_PROG  = 12'b0000_1000_0000,
        ST_POS   = 12'b0001_0000_0000,
        ST_SPDM  = 12'b0010_0000_0000,
        ST_SPDD  = 12'b0100_0000_0000,
        ST_EMIT  = 12'b1000_0000_0000
    } state_t;

    // Unpacked input fields.
    logic [1:0]  in_mode;
    logic [4:0]  in_joint;
    logic [31:0] in_position;
    logic [15:0] in_scale;
    logic        in_has_goal;
    logic [15:0] in_move;
    logic [15:0] in_wait;

    assign in_mode = s_axis_tuser;
    assign in_joint = s_axis_tdata[4:0];
    assign in_position = s_axis_tdata[36:5];
    assign in_scale = s_axis_tdata[52:37];
    assign in_has_goal = s_axis_tdata[53];
    assign in_move = s_axis_tdata[69:54];
    assign in_wait = s_axis_tdata[85:70];

    // Configuration.
    logic [9:0] cycle_ms_reg, cycle_ms_next;
    logic [5:0] active_joints_reg, active_joints_next;

    // Per-joint stores.
    logic [31:0] start_reg [MAX_JOINTS];
    logic [31:0] start_next [MAX_JOINTS];
    logic [31:0] goal_reg [MAX_JOINTS];
    logic [31:0] goal_next [MAX_JOINTS];
    logic        present_reg [MAX_JOINTS];
    logic        present_next [MAX_JOINTS];
    logic [15:0] scale_reg [MAX_JOINTS];
    logic [15:0] scale_next [MAX_JOINTS];
    logic [16:0] jmt_reg [MAX_JOINTS];
    logic [16:0] jmt_next [MAX_JOINTS];

    // Frame state.
    logic [16:0] step_total_reg, step_total_next;
    logic [16:0] step_index_reg, step_index_next;
    logic [16:0] frame_total_reg, frame_total_next;
    logic [31:0] frame_base_reg, frame_base_next;
    logic        frame_active_reg, frame_active_next;

    // Sequencer and working registers.
    state_t      state_reg, state_next;
    logic        issued_reg, issued_next;
    logic        run_active_reg, run_active_next;
    logic [JCW-1:0] j_reg, j_next;
    logic [JCW-1:0] n_reg, n_next;
    logic [16:0] total_reg, total_next;
    logic [15:0] move_reg, move_next;
    logic [16:0] steps_reg, steps_next;
    logic [17:0] k_reg, k_next;
    logic [33:0] num_reg, num_next;
    logic [33:0] den_reg, den_next;
    logic [24:0] p_reg, p_next;
    logic [32:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic [31:0] st_cur_reg, st_cur_next;
    logic [31:0] goal_cur_reg, goal_cur_next;
    logic [16:0] mv_reg, mv_next;
    logic [63:0] prod_reg, prod_next;

    // Output word registers.
    logic [31:0] pos_reg, pos_next;
    logic [31:0] spd_reg, spd_next;
    logic [31:0] tms_reg, tms_next;
    logic        fdone_reg, fdone_next;

    // Shared unit connections.
    alu_req_t         alu_req;
    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    logic             alu_done;
    logic [ALU_W-1:0] alu_res;

    kji_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (alu_a),
        .b       (alu_b),
        .done    (alu_done),
        .result  (alu_res)
    );

    // Combinational helpers.
    logic [JCW-1:0] in_joint_ext;
    logic           in_joint_ok;
    logic [JW-1:0]  in_jidx;
    logic [JW-1:0]  jidx;
    logic [JCW-1:0] aj_ext;
    logic [JCW-1:0] joint_count;
    logic [9:0]     cycle_eff;
    logic [15:0]    scale_eff;
    logic [32:0]    delta;
    logic [31:0]    goal_sel;
    logic [56:0]    prod_mag;
    logic [32:0]    shift_q;
    logic [31:0]    spd_sat;
    logic           alu_go;
    logic           alu_fin;

    assign in_joint_ext = JCW'(in_joint);
    assign in_joint_ok = in_joint_ext < JMAX;
    assign in_jidx = in_joint_ext[JW-1:0];
    assign jidx = j_reg[JW-1:0];
    assign aj_ext = JCW'(active_joints_reg);
    assign joint_count = (aj_ext == '0) ? JCW'(1) : ((aj_ext > JMAX) ? JMAX : aj_ext);
    assign cycle_eff = (cycle_ms_reg == 10'd0) ? 10'd1 : cycle_ms_reg;
    assign scale_eff = (present_reg[jidx] && scale_reg[jidx] != 16'd0) ? scale_reg[jidx]
                                                                       : SCALE_ONE;
    assign goal_sel = present_reg[jidx] ? goal_reg[jidx] : start_reg[jidx];
    assign delta = {goal_sel[31], goal_sel} - {start_reg[jidx][31], start_reg[jidx]};
    assign prod_mag = alu_res[56:0];
    assign shift_q = neg_reg ? 33'((prod_mag + PROG_ROUND) >> PROG_BITS)
                             : 33'(prod_mag >> PROG_BITS);
    assign spd_sat = (alu_res[63:32] != 32'd0) ? 32'hFFFF_FFFF : alu_res[31:0];
    // A compute state starts the shared unit once, then waits for its done pulse.
    assign alu_go = !issued_reg;
    assign alu_fin = issued_reg && alu_done;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tdata = {3'd0, tms_reg, spd_reg, pos_reg, j_reg[4:0]};
    assign m_axis_tlast = (j_reg == n_reg - JCW'(1));
    assign m_axis_tuser = fdone_reg;

    always_comb begin
        cycle_ms_next = cycle_ms_reg;
        active_joints_next = active_joints_reg;
        start_next = start_reg;
        goal_next = goal_reg;
        present_next = present_reg;
        scale_next = scale_reg;
        jmt_next = jmt_reg;
        step_total_next = step_total_reg;
        step_index_next = step_index_reg;
        frame_total_next = frame_total_reg;
        frame_base_next = frame_base_reg;
        frame_active_next = frame_active_reg;
        state_next = state_reg;
        issued_next = issued_reg;
        run_active_next = run_active_reg;
        j_next = j_reg;
        n_next = n_reg;
        total_next = total_reg;
        move_next = move_reg;
        steps_next = steps_reg;
        k_next = k_reg;
        num_next = num_reg;
        den_next = den_reg;
        p_next = p_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        st_cur_next = st_cur_reg;
        goal_cur_next = goal_cur_reg;
        mv_next = mv_reg;
        prod_next = prod_reg;
        pos_next = pos_reg;
        spd_next = spd_reg;
        tms_next = tms_reg;
        fdone_next = fdone_reg;
        alu_req = '0;
        alu_a = '0;
        alu_b = '0;

        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CYCLE_MS: cycle_ms_next = cfg_wdata;
                CFG_ACTIVE_JOINTS: active_joints_next = cfg_wdata[5:0];
                default: ;
            endcase
        end

        if (alu_go) begin
            alu_req.start = (state_reg != ST_IDLE) && (state_reg != ST_LOAD)
                            && (state_reg != ST_EMIT);
            if (alu_req.start) begin
                issued_next = 1'b1;
            end
        end else if (alu_done) begin
            issued_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    case (in_mode)
                        MODE_SET_START: begin
                            if (in_joint_ok) begin
                                start_next[in_jidx] = in_position;
                            end
                        end
                        MODE_SET_GOAL: begin
                            if (in_joint_ok) begin
                                present_next[in_jidx] = in_has_goal;
                                if (in_has_goal) begin
                                    goal_next[in_jidx] = in_position;
                                end
                                scale_next[in_jidx] = in_scale;
                            end
                        end
                        MODE_BEGIN_FRAME: begin
                            total_next = {1'b0, in_move} + {1'b0, in_wait};
                            move_next = in_move;
                            state_next = ST_STEPS;
                        end
                        default: begin
                            n_next = joint_count;
                            k_next = {1'b0, step_index_reg} + 18'd1;
                            j_next = '0;
                            run_active_next = frame_active_reg;
                            // With no frame begun, every word shows the start position at rest.
                            tms_next = frame_base_reg;
                            fdone_next = 1'b0;
                            state_next = frame_active_reg ? ST_NUM : ST_LOAD;
                        end
                    endcase
                end
            end
            ST_STEPS: begin
                alu_req.op = ALU_DIV;
                alu_a = ALU_W'(total_reg);
                alu_b = ALU_W'(cycle_eff);
                if (alu_fin) begin
                    steps_next = (alu_res == '0) ? 17'd1 : alu_res[16:0];
                    j_next = '0;
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE: begin
                // Move time is move_ms scaled by the Q8.8 speed, capped at the frame length.
                alu_req.op = ALU_DIV;
                alu_a = ALU_W'({move_reg, 8'd0});
                alu_b = ALU_W'(scale_eff);
                if (alu_fin) begin
                    jmt_next[jidx] = (alu_res > ALU_W'(total_reg)) ? total_reg : alu_res[16:0];
                    if (j_reg == JLAST) begin
                        frame_total_next = total_reg;
                        step_total_next = steps_reg;
                        step_index_next = '0;
                        frame_active_next = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        j_next = j_reg + JCW'(1);
                    end
                end
            end
            ST_NUM: begin
                alu_req.op = ALU_MUL;
                alu_req.nbits = 7'd17;
                alu_a = ALU_W'(k_reg);
                alu_b = ALU_W'(frame_total_reg);
                if (alu_fin) begin
                    num_next = alu_res[33:0];
                    state_next = ST_TIME;
                end
            end
            ST_TIME: begin
                alu_req.op = ALU_DIV;
                alu_a = ALU_W'(num_reg);
                alu_b = ALU_W'(step_total_reg);
                if (alu_fin) begin
                    tms_next = frame_base_reg + alu_res[31:0];
                    fdone_next = k_reg >= {1'b0, step_total_reg};
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                st_cur_next = start_reg[jidx];
                goal_cur_next = goal_sel;
                neg_next = delta[32];
                mag_next = delta[32] ? -delta : delta;
                mv_next = jmt_reg[jidx];
                if (!run_active_reg || !present_reg[jidx]) begin
                    pos_next = start_reg[jidx];
                    spd_next = '0;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_DEN;
                end
            end
            ST_DEN: begin
                alu_req.op = ALU_MUL;
                alu_req.nbits = 7'd17;
                alu_a = ALU_W'(step_total_reg);
                alu_b = ALU_W'(mv_reg);
                if (alu_fin) begin
                    den_next = alu_res[33:0];
                    if (ALU_W'(num_reg) > alu_res) begin
                        // Move time is over: the joint sits at its goal.
                        pos_next = goal_cur_reg;
                        state_next = ST_SPDM;
                    end else if (mv_reg == 17'd0) begin
                        pos_next = st_cur_reg;
                        state_next = ST_SPDM;
                    end else begin
                        state_next = ST_PROG;
                    end
                end
            end
            ST_PROG: begin
                alu_req.op = ALU_DIV;
                alu_a = ALU_W'(num_reg) << PROG_BITS;
                alu_b = ALU_W'(den_reg);
                if (alu_fin) begin
                    p_next = (alu_res > ALU_W'(PROG_ONE)) ? PROG_ONE : alu_res[24:0];
                    state_next = ST_POS;
                end
            end
            ST_POS: begin
                alu_req.op = ALU_MUL;
                alu_req.nbits = 7'd25;
                alu_a = ALU_W'(mag_reg);
                alu_b = ALU_W'(p_reg);
                if (alu_fin) begin
                    // Floor toward minus infinity, so negative moves round their step up.
                    pos_next = neg_reg ? st_cur_reg - shift_q[31:0] : st_cur_reg + shift_q[31:0];
                    state_next = ST_SPDM;
                end
            end
            ST_SPDM: begin
                alu_req.op = ALU_MUL;
                alu_req.nbits = 7'd20;
                alu_a = ALU_W'(mag_reg);
                alu_b = ALU_W'((mv_reg == 17'd0) ? SPEED_ZERO_MUL : SPEED_MS_MUL);
                if (alu_fin) begin
                    if (mv_reg == 17'd0) begin
                        spd_next = spd_sat;
                        state_next = ST_EMIT;
                    end else begin
                        prod_next = alu_res;
                        state_next = ST_SPDD;
                    end
                end
            end
            ST_SPDD: begin
                alu_req.op = ALU_DIV;
                alu_a = prod_reg;
                alu_b = ALU_W'(mv_reg);
                if (alu_fin) begin
                    spd_next = spd_sat;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_axis_tready) begin
                    if (m_axis_tlast) begin
                        if (run_active_reg) begin
                            if (fdone_reg) begin
                                // Frame end: goals become the new starts.
                                for (int i = 0; i < MAX_JOINTS; i++) begin
                                    if (present_reg[i]) begin
                                        start_next[i] = goal_reg[i];
                                    end
                                    present_next[i] = 1'b0;
                                end
                                frame_base_next = frame_base_reg + 32'(frame_total_reg);
                                frame_active_next = 1'b0;
                                step_index_next = '0;
                            end else begin
                                step_index_next = k_reg[16:0];
                            end
                        end
                        state_next = ST_IDLE;
                    end else begin
                        j_next = j_reg + JCW'(1);
                        state_next = ST_LOAD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cycle_ms_reg <= 10'd8;
            active_joints_reg <= 6'd32;
            for (int i = 0; i < MAX_JOINTS; i++) begin
                start_reg[i] <= '0;
                present_reg[i] <= 1'b0;
                jmt_reg[i] <= '0;
            end
            step_total_reg <= '0;
            step_index_reg <= '0;
            frame_total_reg <= '0;
            frame_base_reg <= '0;
            frame_active_reg <= 1'b0;
            state_reg <= ST_IDLE;
            issued_reg <= 1'b0;
            run_active_reg <= 1'b0;
            j_reg <= '0;
            n_reg <= JCW'(1);
        end else begin
            cycle_ms_reg <= cycle_ms_next;
            active_joints_reg <= active_joints_next;
            start_reg <= start_next;
            present_reg <= present_next;
            jmt_reg <= jmt_next;
            step_total_reg <= step_total_next;
            step_index_reg <= step_index_next;
            frame_total_reg <= frame_total_next;
            frame_base_reg <= frame_base_next;
            frame_active_reg <= frame_active_next;
            state_reg <= state_next;
            issued_reg <= issued_next;
            run_active_reg <= run_active_next;
            j_reg <= j_next;
            n_reg <= n_next;
        end
        goal_reg <= goal_next;
        scale_reg <= scale_next;
        total_reg <= total_next;
        move_reg <= move_next;
        steps_reg <= steps_next;
        k_reg <= k_next;
        num_reg <= num_next;
        den_reg <= den_next;
        p_reg <= p_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        st_cur_reg <= st_cur_next;
        goal_cur_reg <= goal_cur_next;
        mv_reg <= mv_next;
        prod_reg <= prod_next;
        pos_reg <= pos_next;
        spd_reg <= spd_next;
        tms_reg <= tms_next;
        fdone_reg <= fdone_next;
    end

`ifndef SYNTHESIS
    // The input side never opens while an output word is pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while an output word is pending");

    // An active frame always has a nonzero step count to divide by.
    assert property (@(posedge aclk) disable iff (!aresetn)
        frame_active_reg |-> step_total_reg != 17'd0)
        else $error("active frame with zero steps");

    // A frame-done word only comes from a point of an active frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (run_active_reg && frame_active_reg))
        else $error("frame done flagged outside an active frame");

    // The shared unit finishes only while a compute state waits on it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> issued_reg)
        else $error("arithmetic result with no request outstanding");
`endif

endmodule
